// ===== rtl/pfs_pkg.sv =====
// package for the phase field stencil block
// holds payload structs, opcodes, config register map and fixed-point constants
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned ADDR_W     = 2 * COORD_W;
  localparam int unsigned CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CELL_W     = FRAC_BITS + 2;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned NB_CNT     = 5;

  localparam logic [DIM_W-1:0]  MAX_W_Q     = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  MAX_H_Q     = DIM_W'(MAX_HEIGHT);
  localparam logic [COEF_W-1:0] RST_INV_D   = COEF_W'(65536);
  localparam logic [COEF_W-1:0] RST_MOB     = COEF_W'(65536);
  localparam logic [COEF_W-1:0] RST_GRAD    = COEF_W'(65536);
  localparam logic [COEF_W-1:0] RST_TSTEP   = COEF_W'(655);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SWAP   = 2'd2,
    OP_READ   = 2'd3
  } pfs_op_e;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_INV_DX = 3'd2,
    REG_INV_DY = 3'd3,
    REG_MOB    = 3'd4,
    REG_GRAD   = 3'd5,
    REG_TSTEP  = 3'd6,
    REG_NONE   = 3'd7
  } pfs_reg_e;

  typedef struct packed {
    pfs_op_e             opcode;
    logic [5:0]          cell_x;
    logic [5:0]          cell_y;
    logic signed [23:0]  cell_value;
  } pfs_in_t;

  typedef struct packed {
    logic signed [17:0]  result_value;
    logic                out_of_grid;
  } pfs_out_t;

  // classified item handed from front to back
  typedef struct packed {
    pfs_op_e                          op;
    logic                             oob;
    logic signed [23:0]               val;
    logic [NB_CNT-1:0][ADDR_W-1:0]    addr;   // center, left, right, below, above
  } pfs_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] inv_dx;
    logic [COEF_W-1:0] inv_dy;
    logic [COEF_W-1:0] mob;
    logic [COEF_W-1:0] grad;
    logic [COEF_W-1:0] tstep;
  } pfs_cfg_t;

endpackage

// ===== rtl/phase_field_stencil_2d_top.sv =====
// top level of the 2-d allen-cahn stencil: config registers, front and back
// depends on pfs_pkg, pfs_front, pfs_back
`timescale 1ns / 1ps

// usage
//   command channel: drive cmd_i and raise start; the beat is taken at an edge
//   where start is high and busy is low. a two-entry queue sits between the
//   front end and the execution unit, so busy only rises when both are full.
//   result channel: done_o is high for one cycle with result_o; every command
//   gives exactly one result beat, in command order. the receiver cannot stall.
//   write, swap and out-of-grid commands finish in the idle state, read adds
//   a data state, update does five sequential bank reads on the single
//   read port, then a seven-stage multiply and round sequence.
//   the execution unit holds one item at a time and takes the next item only
//   when it has finished the last one.
//   config: apb registers at byte offsets 0x00..0x18, to be written only while
//   idle by the user; the block does not enforce this. pready is tied high.
//   reset: registers return to defaults, bank 0 is current; cell contents are
//   undefined until written.

module phase_field_stencil_2d_top import pfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  pfs_in_t      cmd_i,
  output logic         busy,
  output logic         done_o,
  output pfs_out_t     result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [DIM_W-1:0] gw_q, gh_q, act_w, act_h;
  pfs_cfg_t  cfg_q;
  pfs_reg_e  reg_idx;
  logic      cfg_we, push, pop, head_valid;
  pfs_item_t head;

  assign reg_idx = pfs_reg_e'(paddr[4:2]);
  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q         <= MAX_W_Q;
      gh_q         <= MAX_H_Q;
      cfg_q.inv_dx <= RST_INV_D;
      cfg_q.inv_dy <= RST_INV_D;
      cfg_q.mob    <= RST_MOB;
      cfg_q.grad   <= RST_GRAD;
      cfg_q.tstep  <= RST_TSTEP;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_WIDTH:  gw_q         <= pwdata[DIM_W-1:0];
        REG_HEIGHT: gh_q         <= pwdata[DIM_W-1:0];
        REG_INV_DX: cfg_q.inv_dx <= pwdata[COEF_W-1:0];
        REG_INV_DY: cfg_q.inv_dy <= pwdata[COEF_W-1:0];
        REG_MOB:    cfg_q.mob    <= pwdata[COEF_W-1:0];
        REG_GRAD:   cfg_q.grad   <= pwdata[COEF_W-1:0];
        REG_TSTEP:  cfg_q.tstep  <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(gw_q);
      REG_HEIGHT: prdata = 32'(gh_q);
      REG_INV_DX: prdata = 32'(cfg_q.inv_dx);
      REG_INV_DY: prdata = 32'(cfg_q.inv_dy);
      REG_MOB:    prdata = 32'(cfg_q.mob);
      REG_GRAD:   prdata = 32'(cfg_q.grad);
      REG_TSTEP:  prdata = 32'(cfg_q.tstep);
      default:    prdata = '0;
    endcase
  end

  assign act_w = (gw_q < MAX_W_Q) ? gw_q : MAX_W_Q;
  assign act_h = (gh_q < MAX_H_Q) ? gh_q : MAX_H_Q;
  assign push  = start & ~busy;

  pfs_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .cmd_i(cmd_i),
    .act_w_i(act_w), .act_h_i(act_h), .full_o(busy),
    .pop_i(pop), .head_valid_o(head_valid), .head_o(head)
  );

  pfs_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .head_valid_i(head_valid), .head_i(head),
    .cfg_i(cfg_q), .pop_o(pop), .done_o(done_o), .result_o(result_o)
  );

endmodule

// ===== rtl/pfs_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pfs_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pfs_front.sv =====
// front end: accepts commands, checks grid bounds, forms neighbor addresses
// and queues classified items for the back end; uses pfs_pkg
`timescale 1ns / 1ps

module pfs_front import pfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfs_in_t           cmd_i,
  input  logic [DIM_W-1:0]  act_w_i,
  input  logic [DIM_W-1:0]  act_h_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output pfs_item_t         head_o
);

  pfs_item_t   mem_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  pfs_item_t   item;
  logic [DIM_W-1:0] x_ext, y_ext, x_inc, y_inc;
  logic [5:0]  xl, xr, yb, yt;

  always_comb begin
    x_ext = DIM_W'(cmd_i.cell_x);
    y_ext = DIM_W'(cmd_i.cell_y);
    x_inc = x_ext + DIM_W'(1);
    y_inc = y_ext + DIM_W'(1);
    // edge neighbors fall back to the cell itself
    xl = (cmd_i.cell_x != 6'd0) ? cmd_i.cell_x - 6'd1 : cmd_i.cell_x;
    xr = (x_inc < act_w_i) ? x_inc[5:0] : cmd_i.cell_x;
    yb = (cmd_i.cell_y != 6'd0) ? cmd_i.cell_y - 6'd1 : cmd_i.cell_y;
    yt = (y_inc < act_h_i) ? y_inc[5:0] : cmd_i.cell_y;
    item.op      = cmd_i.opcode;
    item.oob     = (x_ext >= act_w_i) || (y_ext >= act_h_i);
    item.val     = cmd_i.cell_value;
    item.addr[0] = {cmd_i.cell_y, cmd_i.cell_x};
    item.addr[1] = {cmd_i.cell_y, xl};
    item.addr[2] = {cmd_i.cell_y, xr};
    item.addr[3] = {yb, cmd_i.cell_x};
    item.addr[4] = {yt, cmd_i.cell_x};
  end

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item;
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

endmodule

// ===== rtl/pfs_back.sv =====
// back end: executes queued items against the two cell banks, runs the
// stencil update as a multi-cycle fixed-point sequence; uses pfs_pkg, pfs_ram
`timescale 1ns / 1ps

module pfs_back import pfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  pfs_item_t  head_i,
  input  pfs_cfg_t   cfg_i,
  output logic       pop_o,
  output logic       done_o,
  output pfs_out_t   result_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDATA = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_M1    = 10'b0000001000,
    S_M2    = 10'b0000010000,
    S_M3    = 10'b0000100000,
    S_M4    = 10'b0001000000,
    S_M5    = 10'b0010000000,
    S_M6    = 10'b0100000000,
    S_M7    = 10'b1000000000
  } state_e;

  localparam logic signed [CELL_W-1:0] ONE_C = CELL_W'(1 << FRAC_BITS);
  localparam int unsigned SAT_W = 2 * FRAC_BITS + 3;   // |p| clamp point is 2^(SAT_W-1)

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic [2:0] cnt_q, cnt_d;
  pfs_item_t item_q;
  logic signed [CELL_W-1:0] nb_q [NB_CNT];
  logic done_q, done_d;
  pfs_out_t res_q, res_d;

  // datapath registers
  logic signed [44:0] px_q, py_q, px_d, py_d;
  logic signed [35:0] c2p_q, c2p_d, cub_q, cub_d;
  logic signed [29:0] lap_q, lap_d;
  logic signed [17:0] c2_q, c2_d;
  logic [32:0]        md_q, md_d;
  logic signed [54:0] gl_q, gl_d;
  logic signed [40:0] dv_q, dv_d;
  logic [50:0]        ph_q, ph_d;
  logic [51:0]        pl_q, pl_d;
  logic               neg_q, neg_d;
  logic [SAT_W-1:0]   pm_q, pm_d;

  // ram signals
  logic                  we, we0, we1, wbank;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [CELL_W-1:0]     wdata, rd0, rd1, rdata;

  // combinational helpers
  logic signed [CELL_W-1:0] cc, wval, upd;
  logic signed [19:0] lx, ly, rp;
  logic signed [45:0] lsum;
  logic [48:0]        mt;
  logic signed [17:0] c2m;
  logic signed [40:0] ad;
  logic [SAT_W-1:0]   adc;
  logic [52:0]        mag;
  logic               sat;
  logic signed [SAT_W:0] pv;
  logic signed [20:0] diff;

  pfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank0 (
    .clk_i(clk_i), .we_i(we0), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd0)
  );
  pfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank1 (
    .clk_i(clk_i), .we_i(we1), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd1)
  );

  assign rdata = sel_q ? rd1 : rd0;
  assign we0   = we & ~wbank;
  assign we1   = we & wbank;

  always_comb begin
    cc = nb_q[0];
    // write value clamped to +-one
    if (head_i.val > 24'sd65536) begin
      wval = ONE_C;
    end else if (head_i.val < -24'sd65536) begin
      wval = -ONE_C;
    end else begin
      wval = head_i.val[CELL_W-1:0];
    end

    lx   = 20'(nb_q[1]) + 20'(nb_q[2]) - (20'(cc) <<< 1);
    ly   = 20'(nb_q[3]) + 20'(nb_q[4]) - (20'(cc) <<< 1);
    px_d  = 45'(lx) * $signed({21'd0, cfg_i.inv_dx});
    py_d  = 45'(ly) * $signed({21'd0, cfg_i.inv_dy});
    c2p_d = 36'(cc) * 36'(cc);

    lsum  = 46'(px_q) + 46'(py_q) + 46'sd32768;
    lap_d = 30'(lsum >>> FRAC_BITS);
    c2_d  = 18'((c2p_q + 36'sd32768) >>> FRAC_BITS);
    mt    = 49'(cfg_i.mob) * 49'(cfg_i.tstep) + 49'd32768;
    md_d  = 33'(mt >> FRAC_BITS);

    c2m   = c2_q - ONE_C;
    gl_d  = $signed({31'd0, cfg_i.grad}) * 55'(lap_q);
    cub_d = 36'(cc) * 36'(c2m);

    dv_d  = 41'((cub_q + 36'sd32768) >>> FRAC_BITS)
          - 41'((gl_q + 55'sd32768) >>> FRAC_BITS)
          - 41'(item_q.val);

    // anything beyond 2^34 saturates the final clamp either way
    ad    = dv_q[40] ? -dv_q : dv_q;
    adc   = (ad > 41'sd17179869184) ? SAT_W'(35'd17179869184) : ad[SAT_W-1:0];
    ph_d  = 51'(adc) * 51'(md_q[32:17]);
    pl_d  = 52'(adc) * 52'(md_q[16:0]);
    neg_d = dv_q[40];

    sat   = |ph_q[50:17];
    mag   = 53'(pl_q) + (53'(ph_q[16:0]) << 17);
    pm_d  = (sat || mag > 53'd17179869184) ? SAT_W'(35'd17179869184) : mag[SAT_W-1:0];

    pv    = neg_q ? -$signed({1'b0, pm_q}) : $signed({1'b0, pm_q});
    rp    = 20'((pv + 36'sd32768) >>> FRAC_BITS);
    diff  = 21'(cc) - 21'(rp);
    if (diff > 21'sd65536) begin
      upd = ONE_C;
    end else if (diff < -21'sd65536) begin
      upd = -ONE_C;
    end else begin
      upd = diff[CELL_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    done_d  = 1'b0;
    res_d   = '0;
    we      = 1'b0;
    wbank   = sel_q;
    waddr   = head_i.addr[0];
    wdata   = wval;
    raddr   = head_i.addr[0];
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          if (head_i.op == OP_SWAP) begin
            sel_d  = ~sel_q;
            done_d = 1'b1;
          end else if (head_i.oob) begin
            done_d             = 1'b1;
            res_d.out_of_grid  = 1'b1;
          end else begin
            case (head_i.op)
              OP_WRITE: begin
                we                 = 1'b1;
                done_d             = 1'b1;
                res_d.result_value = wval;
              end
              OP_READ: begin
                state_d = S_RDATA;
              end
              default: begin
                cnt_d   = 3'd1;
                state_d = S_FETCH;
              end
            endcase
          end
        end
      end
      S_RDATA: begin
        done_d             = 1'b1;
        res_d.result_value = rdata;
        state_d            = S_IDLE;
      end
      S_FETCH: begin
        raddr = (cnt_q < 3'(NB_CNT)) ? item_q.addr[cnt_q] : item_q.addr[0];
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(NB_CNT)) begin
          state_d = S_M1;
        end
      end
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: state_d = S_M5;
      S_M5: state_d = S_M6;
      S_M6: state_d = S_M7;
      S_M7: begin
        we                 = 1'b1;
        wbank              = ~sel_q;
        waddr              = item_q.addr[0];
        wdata              = upd;
        done_d             = 1'b1;
        res_d.result_value = upd;
        state_d            = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      cnt_q   <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      item_q <= head_i;
    end
    if (state_q == S_FETCH) begin
      nb_q[cnt_q - 3'd1] <= rdata;
    end
    px_q  <= px_d;
    py_q  <= py_d;
    c2p_q <= c2p_d;
    lap_q <= lap_d;
    c2_q  <= c2_d;
    md_q  <= md_d;
    gl_q  <= gl_d;
    cub_q <= cub_d;
    dv_q  <= dv_d;
    ph_q  <= ph_d;
    pl_q  <= pl_d;
    neg_q <= neg_d;
    pm_q  <= pm_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("item taken while back end busy");
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.out_of_grid |-> result_o.result_value == '0)
    else $error("out of grid beat carries a value");
  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_M7 |=> done_o && state_q == S_IDLE)
    else $error("update finished without a result beat");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.out_of_grid && $past(state_q) == S_M7 |->
    result_o.result_value <= 18'sd65536 && result_o.result_value >= -18'sd65536)
    else $error("updated cell outside +-one");
`endif

endmodule
